FILE: hw/rtl/hmr_pkg.sv
// ---------------------------------------------------------------------------
// hmr_pkg
// Types and constants shared by the HID message reassembler.
// ---------------------------------------------------------------------------
package hmr_pkg;

    localparam int          BYTE_W        = 8;
    localparam int          COUNT_W       = 16;
    localparam int          CHAN_W        = 32;
    localparam int          ERR_W         = 3;

    // Bit 7 of header byte 4 marks an init report
    localparam int          TYPE_BIT      = 7;
    localparam logic [15:0] MAX_BYTES_RST = 16'd7609;

    // Report error codes
    localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SHORT   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_COUNT   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NO_MSG  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_CHANNEL = 3'd4;
    localparam logic [ERR_W-1:0] ERR_SEQ     = 3'd5;

    // Configuration register indexes
    localparam logic REG_MAX_BYTES = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] report_byte;
        logic              report_end;
    } report_t;

    typedef struct packed {
        logic               payload_valid;
        logic [BYTE_W-1:0]  payload_byte;
        logic               message_start;
        logic               message_dropped;
        logic [CHAN_W-1:0]  channel_id;
        logic [BYTE_W-1:0]  command;
        logic [COUNT_W-1:0] byte_count;
        logic               message_done;
        logic [ERR_W-1:0]   report_error;
    } result_t;

    // Message and header state carried from byte to byte
    typedef struct packed {
        logic               message_active;
        logic [CHAN_W-1:0]  active_channel;
        logic [BYTE_W-1:0]  expected_sequence;
        logic [COUNT_W-1:0] wanted_bytes;
        logic [COUNT_W-1:0] collected_bytes;
        logic [CHAN_W-1:0]  header_channel;
        logic [BYTE_W-1:0]  header_command;
        logic [COUNT_W-1:0] header_count;
        logic               report_rejected;
        logic [ERR_W-1:0]   pending_error;
    } msg_state_t;

endpackage

FILE: hw/rtl/hmr_step.sv
// ---------------------------------------------------------------------------
// hmr_step
// Per-byte header decode, message checks and payload pass-through.
// ---------------------------------------------------------------------------
module hmr_step #(
    parameter int REPORT_BYTES = 64,
    parameter int POS_W        = $clog2(REPORT_BYTES + 1)
) (
    input  hmr_pkg::report_t    item,
    input  hmr_pkg::msg_state_t st,
    input  logic [POS_W-1:0]    pos,
    input  logic [15:0]         max_bytes,
    output hmr_pkg::msg_state_t st_next,
    output logic [POS_W-1:0]    pos_next,
    output hmr_pkg::result_t    res
);

    localparam logic [POS_W-1:0] POS_END = POS_W'(REPORT_BYTES);
    localparam logic [POS_W-1:0] POS_CMD = POS_W'(4);
    localparam logic [POS_W-1:0] POS_CHI = POS_W'(5);
    localparam logic [POS_W-1:0] POS_CLO = POS_W'(6);
    localparam logic [POS_W-1:0] POS_IPL = POS_W'(7);

    logic        is_init;
    logic [7:0]  b;
    logic [15:0] cnt;
    logic        in_payload;

    always_comb
    begin
        st_next    = st;
        pos_next   = pos;
        res        = '0;
        b          = item.report_byte;
        is_init    = st.header_command[hmr_pkg::TYPE_BIT];
        cnt        = {st.header_count[7:0], b};
        in_payload = 1'b0;

        if (pos < POS_END)
        begin
            if (pos < POS_CMD)
            begin
                if (pos == '0)
                begin
                    st_next.header_channel = '0;
                end
                st_next.header_channel[8*pos[1:0] +: 8] = b;
            end
            else if (pos == POS_CMD)
            begin
                st_next.header_command = b;
                is_init = b[hmr_pkg::TYPE_BIT];
                if (!is_init && !st.report_rejected)
                begin
                    if (!st.message_active)
                    begin
                        st_next.report_rejected = 1'b1;
                        st_next.pending_error   = hmr_pkg::ERR_NO_MSG;
                    end
                    else if (st.header_channel != st.active_channel)
                    begin
                        st_next.report_rejected = 1'b1;
                        st_next.pending_error   = hmr_pkg::ERR_CHANNEL;
                    end
                    else if (b != st.expected_sequence)
                    begin
                        st_next.report_rejected = 1'b1;
                        st_next.pending_error   = hmr_pkg::ERR_SEQ;
                    end
                    else
                    begin
                        st_next.expected_sequence = b + 8'd1;
                    end
                end
            end
            else if (pos == POS_CHI && is_init)
            begin
                st_next.header_count = {8'd0, b};
            end
            else if (pos == POS_CLO && is_init && !st.report_rejected)
            begin
                st_next.header_count = cnt;
                if (cnt > max_bytes)
                begin
                    st_next.report_rejected = 1'b1;
                    st_next.pending_error   = hmr_pkg::ERR_COUNT;
                end
                else
                begin
                    res.message_start         = 1'b1;
                    res.message_dropped       = st.message_active;
                    res.channel_id            = st.header_channel;
                    res.command               = st.header_command;
                    res.byte_count            = cnt;
                    st_next.message_active    = 1'b1;
                    st_next.active_channel    = st.header_channel;
                    st_next.expected_sequence = '0;
                    st_next.wanted_bytes      = cnt;
                    st_next.collected_bytes   = '0;
                end
            end

            in_payload = is_init ? (pos >= POS_IPL) : (pos >= POS_CHI);
            if (!st_next.report_rejected && st_next.message_active && in_payload &&
                (st_next.collected_bytes < st_next.wanted_bytes))
            begin
                res.payload_valid       = 1'b1;
                res.payload_byte        = b;
                st_next.collected_bytes = st_next.collected_bytes + 16'd1;
            end
            pos_next = pos + POS_W'(1);
        end

        if (item.report_end)
        begin
            if (st_next.report_rejected)
            begin
                res.report_error = st_next.pending_error;
            end
            else if ((pos < POS_CMD) || (is_init && (pos < POS_CLO)))
            begin
                res.report_error = hmr_pkg::ERR_SHORT;
            end
            if ((res.report_error == hmr_pkg::ERR_OK) && st_next.message_active &&
                (st_next.collected_bytes >= st_next.wanted_bytes))
            begin
                res.message_done       = 1'b1;
                st_next.message_active = 1'b0;
            end
            pos_next                = '0;
            st_next.report_rejected = 1'b0;
            st_next.pending_error   = hmr_pkg::ERR_OK;
        end
    end

endmodule

FILE: hw/rtl/hid_message_reassembler.sv
// ---------------------------------------------------------------------------
// hid_message_reassembler
// Reassembles HID messages from a byte stream of init and continuation reports.
// ---------------------------------------------------------------------------
// Takes one report byte per cycle while report_stall is low and gives one
// result per byte, each byte passing the input register, then the result
// register. Each byte is decoded against the message state combinationally, so
// bytes may arrive back to back; the input register takes one more byte while a
// result waits on a stalled output, then the input stalls. Payload bytes are
// flagged with payload_valid; message_start, channel_id, command and
// byte_count appear on byte 6 of an accepted init report, and report_error
// and message_done on the byte carrying report_end. max_message_bytes sits at
// APB address 0.
module hid_message_reassembler #(
    parameter int REPORT_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              report_valid,
    output logic              report_stall,
    input  hmr_pkg::report_t  report,
    output logic              result_valid,
    input  logic              result_stall,
    output hmr_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int POS_W = $clog2(REPORT_BYTES + 1);

    logic                 item_valid_reg;
    logic                 item_valid_next;
    hmr_pkg::report_t     item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    hmr_pkg::result_t     out_reg;
    hmr_pkg::msg_state_t  state_reg;
    hmr_pkg::msg_state_t  state_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [15:0]          max_bytes_reg;
    hmr_pkg::result_t     step_res;
    logic                 advance;
    logic                 take;
    logic                 cfg_wr;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == hmr_pkg::REG_MAX_BYTES);
    assign prdata = (paddr[2] == hmr_pkg::REG_MAX_BYTES) ? {16'd0, max_bytes_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= hmr_pkg::MAX_BYTES_RST;
        end
        else if (cfg_wr)
        begin
            max_bytes_reg <= pwdata[15:0];
        end
    end

    // Flow control: the held byte moves on when the result register is free
    assign advance         = item_valid_reg && (!out_valid_reg || !result_stall);
    assign report_stall    = item_valid_reg && !advance;
    assign take            = report_valid && !report_stall;
    assign item_valid_next = take || (item_valid_reg && !advance);
    assign out_valid_next  = advance || (out_valid_reg && result_stall);

    hmr_step #(
        .REPORT_BYTES (REPORT_BYTES),
        .POS_W        (POS_W)
    ) u_step (
        .item      (item_reg),
        .st        (state_reg),
        .pos       (pos_reg),
        .max_bytes (max_bytes_reg),
        .st_next   (state_next),
        .pos_next  (pos_next),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= report;
        end
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Checks
    a_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.message_start |-> result.report_error == hmr_pkg::ERR_OK)
        else $error("message start reported with an error");

    a_drop_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.message_dropped |-> result.message_start)
        else $error("message dropped without a message start");

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("held report byte lost while output stalled");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(REPORT_BYTES))
        else $error("byte position beyond report length");

endmodule

FILE: bench/hid_message_reassembler_tb.sv
// ---------------------------------------------------------------------------
// hid_message_reassembler_tb
// Feeds report byte streams into the reassembler and checks every result
// transfer in order against a byte-level prediction of the message state,
// with bursty input, random and patterned output stalls and several size limits.
// ---------------------------------------------------------------------------
module hid_message_reassembler_tb;

    localparam int REPORT_LEN  = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 6;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0]                data;
        logic                      last;
        logic                      pinned;
        logic [hmr_pkg::ERR_W-1:0] err;
    } dir_row_t;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              report_valid = 1'b0;
    logic              report_stall;
    hmr_pkg::report_t  report       = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    hmr_pkg::result_t  result;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [2:0]        paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;

    // predicted block state
    logic [15:0]               max_len     = hmr_pkg::MAX_BYTES_RST;
    logic                      in_message  = 1'b0;
    logic [31:0]               cur_channel = '0;
    logic [7:0]                next_seq    = '0;
    logic [15:0]               msg_len     = '0;
    logic [15:0]               msg_got     = '0;
    logic [6:0]                rpt_pos     = '0;
    logic [31:0]               hdr_chan    = '0;
    logic [7:0]                hdr_cmd     = '0;
    logic [15:0]               hdr_len     = '0;
    logic                      rpt_refused = 1'b0;
    logic [hmr_pkg::ERR_W-1:0] refuse_code = hmr_pkg::ERR_OK;

    hmr_pkg::result_t expected_results [$];
    hmr_pkg::result_t want_res;
    logic [7:0]  report_bytes [$];
    logic [31:0] chan_pool [4];
    dir_row_t    directed_rows [22];
    int          errors      = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    int          hold_left   = 0;
    int          mode_left   = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    logic        hold_request = 1'b0;

    hid_message_reassembler #(
        .REPORT_BYTES (REPORT_LEN)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void refuse(input logic [hmr_pkg::ERR_W-1:0] code);
        rpt_refused = 1'b1;
        refuse_code = code;
    endfunction

    // One report byte through the header decode and payload collection
    function automatic hmr_pkg::result_t reassemble_byte(input logic [7:0] data,
                                                         input logic last);
        hmr_pkg::result_t res;
        logic [6:0]       p;
        logic             init_rpt;
        res      = '0;
        p        = rpt_pos;
        init_rpt = hdr_cmd[hmr_pkg::TYPE_BIT];
        if (p < REPORT_LEN)
        begin
            if (p == 0)
                hdr_chan = '0;
            if (p < 4)
                hdr_chan[8*p +: 8] = data;
            else if (p == 4)
            begin
                hdr_cmd  = data;
                init_rpt = data[hmr_pkg::TYPE_BIT];
                if (!init_rpt && !rpt_refused)
                begin
                    if (!in_message)
                        refuse(hmr_pkg::ERR_NO_MSG);
                    else if (hdr_chan != cur_channel)
                        refuse(hmr_pkg::ERR_CHANNEL);
                    else if (data != next_seq)
                        refuse(hmr_pkg::ERR_SEQ);
                    else
                        next_seq = data + 8'd1;
                end
            end
            else if (p == 5 && init_rpt)
                hdr_len = {8'h00, data};
            else if (p == 6 && init_rpt && !rpt_refused)
            begin
                hdr_len = {hdr_len[7:0], data};
                if (hdr_len > max_len)
                    refuse(hmr_pkg::ERR_COUNT);
                else
                begin
                    res.message_start   = 1'b1;
                    res.message_dropped = in_message;
                    res.channel_id      = hdr_chan;
                    res.command         = hdr_cmd;
                    res.byte_count      = hdr_len;
                    in_message  = 1'b1;
                    cur_channel = hdr_chan;
                    next_seq    = '0;
                    msg_len     = hdr_len;
                    msg_got     = '0;
                end
            end
            if (!rpt_refused && in_message && (init_rpt ? p >= 7 : p >= 5)
                && msg_got < msg_len)
            begin
                res.payload_valid = 1'b1;
                res.payload_byte  = data;
                msg_got           = msg_got + 16'd1;
            end
            rpt_pos = p + 7'd1;
        end
        if (last)
        begin
            if (rpt_refused)
                res.report_error = refuse_code;
            else if (p < 4 || (init_rpt && p < 6))
                res.report_error = hmr_pkg::ERR_SHORT;
            if (res.report_error == hmr_pkg::ERR_OK && in_message && msg_got >= msg_len)
            begin
                res.message_done = 1'b1;
                in_message       = 1'b0;
            end
            rpt_pos     = '0;
            rpt_refused = 1'b0;
            refuse_code = hmr_pkg::ERR_OK;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                want_res = expected_results.pop_front();
                check_field("payload_valid", 32'(want_res.payload_valid),
                            32'(result.payload_valid));
                check_field("payload_byte", 32'(want_res.payload_byte),
                            32'(result.payload_byte));
                check_field("message_start", 32'(want_res.message_start),
                            32'(result.message_start));
                check_field("message_dropped", 32'(want_res.message_dropped),
                            32'(result.message_dropped));
                check_field("channel_id", want_res.channel_id, result.channel_id);
                check_field("command", 32'(want_res.command), 32'(result.command));
                check_field("byte_count", 32'(want_res.byte_count),
                            32'(result.byte_count));
                check_field("message_done", 32'(want_res.message_done),
                            32'(result.message_done));
                check_field("report_error", 32'(want_res.report_error),
                            32'(result.report_error));
            end
        end
    end

    // Output side: long hold-off on request, otherwise rotating stall patterns
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(16, 96);
            end
            else
                mode_left = mode_left - 1;
            case (stall_mode)
                STALL_NONE:   result_stall <= 1'b0;
                STALL_RANDOM: result_stall <= ($urandom_range(0, 99) < 40);
                default:      result_stall <= cycle_count[1];
            endcase
        end
    end

    // Called at a rising edge; returns at the edge of the transfer
    task automatic send_byte(input logic [7:0] data, input logic last, input logic pinned,
                             input logic [hmr_pkg::ERR_W-1:0] err);
        hmr_pkg::result_t res;
        if (burst_left == 0)
        begin
            report_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        report_valid <= 1'b1;
        report       <= '{report_byte: data, report_end: last};
        do
            @(posedge clk);
        while (report_stall);
        res = reassemble_byte(data, last);
        if (pinned)
            res.report_error = err;
        expected_results.push_back(res);
        items_sent++;
    endtask

    task automatic send_report();
        foreach (report_bytes[i])
            send_byte(report_bytes[i], i == report_bytes.size() - 1, 1'b0,
                      hmr_pkg::ERR_OK);
        report_bytes.delete();
    endtask

    task automatic drain_results();
        report_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic push_header(input logic [31:0] chan, input logic [7:0] b4);
        for (int i = 0; i < 4; i++)
            report_bytes.push_back(chan[8*i +: 8]);
        report_bytes.push_back(b4);
    endtask

    task automatic pad_to(input int len);
        while (report_bytes.size() < len)
            report_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Mostly short reports; now and then one reaching past the report size
    function automatic int report_len(input int hdr);
        if ($urandom_range(0, 99) < 8)
            return $urandom_range(60, 70);
        return hdr + $urandom_range(0, 16);
    endfunction

    task automatic build_random_report();
        int          pick;
        logic [31:0] chan;
        logic [7:0]  seq;
        logic [15:0] count;
        pick = $urandom_range(0, 99);
        chan = ($urandom_range(0, 9) == 0) ? $urandom : chan_pool[$urandom_range(0, 3)];
        if (in_message && pick < 55)
        begin
            push_header(cur_channel, next_seq);
            pad_to(report_len(5));
        end
        else if (pick < 80)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                count = 16'($urandom_range(0, 40));
            else if (pick < 75)
                count = max_len;
            else if (pick < 85)
                count = max_len + 16'd1;
            else
                count = 16'($urandom);
            push_header(chan, 8'h80 | 8'($urandom_range(0, 127)));
            report_bytes.push_back(count[15:8]);
            report_bytes.push_back(count[7:0]);
            pad_to(report_len(7));
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: pad_to($urandom_range(1, 4));
                1:
                begin
                    // init cut off before its count is complete
                    push_header(chan, 8'h80 | 8'($urandom_range(0, 127)));
                    pad_to($urandom_range(5, 6));
                end
                2:
                begin
                    push_header(cur_channel ^ (32'd1 << $urandom_range(0, 31)), next_seq);
                    pad_to(report_len(5));
                end
                3:
                begin
                    seq = {1'b0, next_seq[6:0] + 7'($urandom_range(1, 127))};
                    push_header(cur_channel, seq);
                    pad_to(report_len(5));
                end
                default: pad_to($urandom_range(1, 70));
            endcase
        end
    endtask

    task automatic run_random(input int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            build_random_report();
            send_report();
        end
    endtask

    task automatic set_max_len(input logic [15:0] value);
        drain_results();
        repeat (SETTLE) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {hmr_pkg::REG_MAX_BYTES, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        max_len = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("max_message_bytes", {16'h0000, value}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        chan_pool[0] = 32'h0000_0000;
        chan_pool[1] = 32'hFFFF_FFFF;
        chan_pool[2] = $urandom;
        chan_pool[3] = $urandom;

        directed_rows = '{
            // report ending inside the channel id
            {8'hFF, 1'b0, 1'b0, hmr_pkg::ERR_OK}, {8'hFF, 1'b0, 1'b0, hmr_pkg::ERR_OK},
            {8'hFF, 1'b1, 1'b1, hmr_pkg::ERR_SHORT},
            // continuation with no message open
            {8'h01, 1'b0, 1'b0, hmr_pkg::ERR_OK}, {8'h02, 1'b0, 1'b0, hmr_pkg::ERR_OK},
            {8'h03, 1'b0, 1'b0, hmr_pkg::ERR_OK}, {8'h04, 1'b0, 1'b0, hmr_pkg::ERR_OK},
            {8'h00, 1'b1, 1'b1, hmr_pkg::ERR_NO_MSG},
            // init announcing more than the limit
            {8'h11, 1'b0, 1'b0, hmr_pkg::ERR_OK}, {8'h22, 1'b0, 1'b0, hmr_pkg::ERR_OK},
            {8'h33, 1'b0, 1'b0, hmr_pkg::ERR_OK}, {8'h44, 1'b0, 1'b0, hmr_pkg::ERR_OK},
            {8'hC1, 1'b0, 1'b0, hmr_pkg::ERR_OK}, {8'hFF, 1'b0, 1'b0, hmr_pkg::ERR_OK},
            {8'hFF, 1'b1, 1'b1, hmr_pkg::ERR_COUNT},
            // empty message completes on its own init
            {8'h00, 1'b0, 1'b0, hmr_pkg::ERR_OK}, {8'h00, 1'b0, 1'b0, hmr_pkg::ERR_OK},
            {8'h00, 1'b0, 1'b0, hmr_pkg::ERR_OK}, {8'h00, 1'b0, 1'b0, hmr_pkg::ERR_OK},
            {8'h80, 1'b0, 1'b0, hmr_pkg::ERR_OK}, {8'h00, 1'b0, 1'b0, hmr_pkg::ERR_OK},
            {8'h00, 1'b1, 1'b1, hmr_pkg::ERR_OK}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].pinned, directed_rows[i].err);

        run_random(100);
        hold_request = 1'b1;
        run_random(150);

        set_max_len(16'h0000);
        run_random(120);

        set_max_len(16'hFFFF);
        // one message carried over a run of continuations, then one whose sequence restarts at zero
        push_header(chan_pool[2], 8'h80);
        report_bytes.push_back(8'h00);
        report_bytes.push_back(8'h01);
        send_report();
        repeat (130)
        begin
            push_header(cur_channel, next_seq);
            send_report();
        end
        push_header(cur_channel, 8'h00);
        send_report();
        run_random(100);
        drain_results();
        run_random(100);

        set_max_len(16'($urandom_range(1, 64)));
        run_random(100);

        set_max_len(hmr_pkg::MAX_BYTES_RST);
        run_random(80);

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
